// ===== sv/tar_pkg.sv =====
// Shared types and constants for the tetrahedron aspect ratio pipeline.
package tar_pkg;

    localparam int RATIO_W   = 32;  // Q16.16 result
    localparam int OUT_FRAC  = 16;  // fraction bits of the result
    localparam int SQ_PAD    = 32;  // square roots are taken of x * 2^32
    localparam int SQRT_STEP = 2;   // argument bits consumed per root digit
    localparam int K_W       = 35;

    // round(2*sqrt(6) * 2^32)
    localparam logic [K_W-1:0] TWO_SQRT6_Q32 = 35'd21040956674;

    typedef logic [RATIO_W-1:0] t_ratio;

endpackage

// ===== sv/tetra_aspect_ratio.sv =====
// Tetrahedron aspect ratio: longest edge over 2*sqrt(6) times inradius, pipelined.
//
// Takes one tetrahedron (four corners, signed fixed point) per word and returns
// ratio = L*F / (2*sqrt(6)*|6V|) in unsigned Q16.16, where L is the longest of
// the edges and F the sum of the four face cross-product norms; the input
// fraction bits cancel. A zero volume gives all ones with o_degenerate set; a
// quotient too large for 32 bits gives all ones with o_degenerate clear.
// Throughput is one word per clock while o_stall is low. From input accept to
// o_valid, a word passes through five arithmetic stages,
// a row of 2*COORD_WIDTH+18 square-root digit cells (five lanes side by side:
// longest edge and four faces), four multiply/assemble stages, a row of 32
// quotient-bit cells, and the output register. The whole pipeline advances
// together; a two-entry output buffer (output register plus skid) lets it keep
// running while the consumer holds i_stall, and o_stall is raised only once
// both entries are full. o_stall comes straight from a flop.
module tetra_aspect_ratio import tar_pkg::*; #(
    parameter int COORD_WIDTH = 16      // 8 to 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_z,
    input  logic signed [COORD_WIDTH-1:0] i_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_z,
    input  logic signed [COORD_WIDTH-1:0] i_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_c_z,
    input  logic signed [COORD_WIDTH-1:0] i_d_x,
    input  logic signed [COORD_WIDTH-1:0] i_d_y,
    input  logic signed [COORD_WIDTH-1:0] i_d_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output t_ratio                        o_ratio,
    output logic                          o_degenerate
);

    // ---------------------------------------------------------------- widths
    localparam int W      = COORD_WIDTH;
    localparam int DF_W   = W + 1;          // coordinate difference
    localparam int SQ1_W  = 2 * W;          // one squared difference
    localparam int ES_W   = 2 * W + 2;      // squared edge length
    localparam int XP_W   = 2 * W + 2;      // one cross-product term
    localparam int CR_W   = 2 * W + 3;      // cross-product component
    localparam int CA_W   = 2 * W + 2;      // its magnitude
    localparam int CS_W   = 4 * W + 4;      // squared component / face norm^2
    localparam int AL_W   = 3 * W + 4;      // signed 6*volume
    localparam int VOL_W  = 3 * W + 3;      // |6*volume|
    localparam int RW     = 2 * W + 18;     // root width, = digit cells
    localparam int SQ_AW  = 2 * RW;         // root argument width
    localparam int LQ_W   = W + 17;         // longest edge, Q.16
    localparam int FQ_W   = RW + 2;         // sum of face norms, Q.16
    localparam int FH     = FQ_W / 2;       // split point of F for multiply
    localparam int VH     = (VOL_W + 1) / 2;
    localparam int PPL_W  = LQ_W + FH;
    localparam int PPH_W  = LQ_W + FQ_W - FH;
    localparam int DL_W   = VH + K_W;
    localparam int DH_W   = VOL_W - VH + K_W;
    localparam int N_W    = LQ_W + FQ_W + OUT_FRAC;
    localparam int DEN_W  = VOL_W + K_W;
    localparam int NH_W   = N_W - RATIO_W;
    localparam int N_LANE = 5;
    localparam int NSTG   = 5 + RW + 4 + RATIO_W;

    // edge and face numbering
    localparam int E_AB = 0, E_AC = 1, E_AD = 2, E_BC = 3, E_BD = 4, E_CD = 5;
    localparam int EDGE_P [0:5] = '{0, 0, 0, 1, 1, 2};
    localparam int EDGE_Q [0:5] = '{1, 2, 3, 2, 3, 3};
    localparam int FACE_U [0:3] = '{E_AB, E_AB, E_AC, E_BC};
    localparam int FACE_V [0:3] = '{E_AC, E_AD, E_AD, E_BD};
    localparam int FACE_VOL  = 2;   // (c-a) x (d-a), dotted with b-a for 6V
    localparam int LANE_EDGE = 0;   // root lane of the longest edge

    // --------------------------------------------------------- flow control
    logic            w_adv;
    logic            r_skid_vld;    // skid entry of the output buffer holds a word
    logic [NSTG-1:0] r_vld;         // bit 0 is the first stage

    assign w_adv   = !r_skid_vld;
    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // ------------------------------------------------ S1: edge vectors
    logic signed [W-1:0]    w_pt  [0:3][0:2];
    logic signed [DF_W-1:0] n_e   [0:5][0:2];
    logic signed [DF_W-1:0] r_e   [0:5][0:2];

    assign w_pt[0] = '{i_a_x, i_a_y, i_a_z};
    assign w_pt[1] = '{i_b_x, i_b_y, i_b_z};
    assign w_pt[2] = '{i_c_x, i_c_y, i_c_z};
    assign w_pt[3] = '{i_d_x, i_d_y, i_d_z};

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_e[i][k] = DF_W'(w_pt[EDGE_Q[i]][k]) - DF_W'(w_pt[EDGE_P[i]][k]);
            end
        end
    end

    // ------------------------------------------------ S2: products
    logic        [SQ1_W-1:0] n_esq [0:5][0:2];
    logic        [SQ1_W-1:0] r_esq [0:5][0:2];
    logic signed [XP_W-1:0]  n_xp  [0:3][0:5];
    logic signed [XP_W-1:0]  r_xp  [0:3][0:5];
    logic signed [DF_W-1:0]  r_ab2 [0:2];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_esq[i][k] = SQ1_W'(SQ1_W'(r_e[i][k]) * SQ1_W'(r_e[i][k]));
            end
        end
        for (int f = 0; f < 4; f++) begin
            n_xp[f][0] = XP_W'(r_e[FACE_U[f]][1]) * XP_W'(r_e[FACE_V[f]][2]);
            n_xp[f][1] = XP_W'(r_e[FACE_U[f]][2]) * XP_W'(r_e[FACE_V[f]][1]);
            n_xp[f][2] = XP_W'(r_e[FACE_U[f]][2]) * XP_W'(r_e[FACE_V[f]][0]);
            n_xp[f][3] = XP_W'(r_e[FACE_U[f]][0]) * XP_W'(r_e[FACE_V[f]][2]);
            n_xp[f][4] = XP_W'(r_e[FACE_U[f]][0]) * XP_W'(r_e[FACE_V[f]][1]);
            n_xp[f][5] = XP_W'(r_e[FACE_U[f]][1]) * XP_W'(r_e[FACE_V[f]][0]);
        end
    end

    // ------------------------------------------------ S3: sums, cross vectors
    logic        [ES_W-1:0] n_esum [0:5];
    logic        [ES_W-1:0] r_esum [0:5];
    logic signed [CR_W-1:0] n_cr   [0:3][0:2];
    logic signed [CR_W-1:0] r_cr   [0:3][0:2];
    logic signed [DF_W-1:0] r_ab3  [0:2];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_esum[i] = ES_W'(r_esq[i][0]) + ES_W'(r_esq[i][1]) + ES_W'(r_esq[i][2]);
        end
        for (int f = 0; f < 4; f++) begin
            for (int k = 0; k < 3; k++) begin
                n_cr[f][k] = CR_W'(r_xp[f][2*k]) - CR_W'(r_xp[f][2*k+1]);
            end
        end
    end

    // ------------------------------------------------ S4: max edge, squares, 6V terms
    logic        [ES_W-1:0] n_m0, n_m1, n_m2, n_m01, n_maxsq;
    logic        [ES_W-1:0] r_maxsq4;
    logic        [CA_W-1:0] n_ca  [0:3][0:2];
    logic        [CS_W-1:0] n_csq [0:3][0:2];
    logic        [CS_W-1:0] r_csq [0:3][0:2];
    logic signed [AL_W-1:0] n_ap  [0:2];
    logic signed [AL_W-1:0] r_ap  [0:2];

    always_comb begin
        n_m0    = (r_esum[0] > r_esum[1]) ? r_esum[0] : r_esum[1];
        n_m1    = (r_esum[2] > r_esum[3]) ? r_esum[2] : r_esum[3];
        n_m2    = (r_esum[4] > r_esum[5]) ? r_esum[4] : r_esum[5];
        n_m01   = (n_m0 > n_m1) ? n_m0 : n_m1;
        n_maxsq = (n_m01 > n_m2) ? n_m01 : n_m2;
        for (int f = 0; f < 4; f++) begin
            for (int k = 0; k < 3; k++) begin
                n_ca[f][k]  = r_cr[f][k][CR_W-1] ? CA_W'(-r_cr[f][k]) : CA_W'(r_cr[f][k]);
                n_csq[f][k] = CS_W'(n_ca[f][k]) * CS_W'(n_ca[f][k]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_ap[k] = AL_W'(r_ab3[k]) * AL_W'(r_cr[FACE_VOL][k]);
        end
    end

    // ------------------------------------------------ S5: face norm^2, 6V
    logic        [CS_W-1:0] n_fs [0:3];
    logic        [CS_W-1:0] r_fs [0:3];
    logic        [ES_W-1:0] r_maxsq5;
    logic signed [AL_W-1:0] n_alpha;
    logic signed [AL_W-1:0] r_alpha;

    always_comb begin
        for (int f = 0; f < 4; f++) begin
            n_fs[f] = r_csq[f][0] + r_csq[f][1] + r_csq[f][2];
        end
        n_alpha = r_ap[0] + r_ap[1] + r_ap[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e      <= n_e;
            r_esq    <= n_esq;
            r_xp     <= n_xp;
            r_ab2    <= r_e[E_AB];
            r_esum   <= n_esum;
            r_cr     <= n_cr;
            r_ab3    <= r_ab2;
            r_maxsq4 <= n_maxsq;
            r_csq    <= n_csq;
            r_ap     <= n_ap;
            r_fs     <= n_fs;
            r_maxsq5 <= r_maxsq4;
            r_alpha  <= n_alpha;
        end
    end

    // ------------------------------------------------ square-root cell rows
    logic [RW+1:0]    w_sq_rem  [0:N_LANE-1][0:RW];
    logic [RW-1:0]    w_sq_root [0:N_LANE-1][0:RW];
    logic [SQ_AW-1:0] w_sq_arg  [0:N_LANE-1][0:RW];
    logic [VOL_W-1:0] n_vol;
    logic [VOL_W-1:0] r_svol [0:RW-1];
    logic             r_sdeg [0:RW-1];

    assign w_sq_arg[LANE_EDGE][0] = SQ_AW'({r_maxsq5, {SQ_PAD{1'b0}}});

    for (genvar gf = 0; gf < 4; gf++) begin : g_face_arg
        assign w_sq_arg[gf+1][0] = {r_fs[gf], {SQ_PAD{1'b0}}};
    end

    always_comb begin
        n_vol = r_alpha[AL_W-1] ? VOL_W'(-r_alpha) : VOL_W'(r_alpha);
    end

    for (genvar gl = 0; gl < N_LANE; gl++) begin : g_lane
        assign w_sq_rem[gl][0]  = '0;
        assign w_sq_root[gl][0] = '0;
        for (genvar gk = 0; gk < RW; gk++) begin : g_cell
            tar_sqrt_cell #(.ROOT_W(RW)) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_adv),
                .i_rem  (w_sq_rem[gl][gk]),
                .i_root (w_sq_root[gl][gk]),
                .i_arg  (w_sq_arg[gl][gk]),
                .o_rem  (w_sq_rem[gl][gk+1]),
                .o_root (w_sq_root[gl][gk+1]),
                .o_arg  (w_sq_arg[gl][gk+1])
            );
        end
    end

    // volume and degenerate flag ride alongside the root cells
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_svol[0] <= n_vol;
            r_sdeg[0] <= (r_alpha == '0);
            for (int k = 1; k < RW; k++) begin
                r_svol[k] <= r_svol[k-1];
                r_sdeg[k] <= r_sdeg[k-1];
            end
        end
    end

    // ------------------------------------------------ M1..M4: numerator, denominator
    logic [LQ_W-1:0]  r_lq;
    logic [FQ_W-1:0]  r_fq;
    logic [VOL_W-1:0] r_vol1;
    logic             r_deg1, r_deg2, r_deg3, r_deg4;
    logic [PPL_W-1:0] r_ppl;
    logic [PPH_W-1:0] r_pph;
    logic [DL_W-1:0]  r_dl;
    logic [DH_W-1:0]  r_dh;
    logic [N_W-1:0]   n_num, r_num;
    logic [DEN_W-1:0] n_den, r_den;
    logic [NH_W-1:0]  n_nhi;
    logic [DEN_W-1:0] r_rem4, r_den4;
    t_ratio           r_nlo4;
    logic             r_sat4;

    always_comb begin
        n_num = ((N_W'(r_pph) << FH) + N_W'(r_ppl)) << OUT_FRAC;
        n_den = (DEN_W'(r_dh) << VH) + DEN_W'(r_dl);
        n_nhi = r_num[N_W-1:RATIO_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // M1
            r_lq   <= w_sq_root[LANE_EDGE][RW][LQ_W-1:0];
            r_fq   <= FQ_W'(w_sq_root[1][RW]) + FQ_W'(w_sq_root[2][RW])
                    + FQ_W'(w_sq_root[3][RW]) + FQ_W'(w_sq_root[4][RW]);
            r_vol1 <= r_svol[RW-1];
            r_deg1 <= r_sdeg[RW-1];
            // M2: partial products, each with one operand split in half
            r_ppl  <= PPL_W'(r_lq) * PPL_W'(r_fq[FH-1:0]);
            r_pph  <= PPH_W'(r_lq) * PPH_W'(r_fq[FQ_W-1:FH]);
            r_dl   <= DL_W'(r_vol1[VH-1:0]) * DL_W'(TWO_SQRT6_Q32);
            r_dh   <= DH_W'(r_vol1[VOL_W-1:VH]) * DH_W'(TWO_SQRT6_Q32);
            r_deg2 <= r_deg1;
            // M3
            r_num  <= n_num;
            r_den  <= n_den;
            r_deg3 <= r_deg2;
            // M4: quotient overflows 32 bits iff the top of N reaches D
            r_rem4 <= DEN_W'(n_nhi);
            r_nlo4 <= r_num[RATIO_W-1:0];
            r_den4 <= r_den;
            r_sat4 <= (DEN_W'(n_nhi) >= r_den);
            r_deg4 <= r_deg3;
        end
    end

    // ------------------------------------------------ divider cell row
    logic [DEN_W-1:0] w_dv_rem [0:RATIO_W];
    t_ratio           w_dv_num [0:RATIO_W];
    logic [DEN_W-1:0] w_dv_den [0:RATIO_W];
    t_ratio           w_dv_quo [0:RATIO_W];
    logic             r_dsat [0:RATIO_W-1];
    logic             r_ddeg [0:RATIO_W-1];

    assign w_dv_rem[0] = r_rem4;
    assign w_dv_num[0] = r_nlo4;
    assign w_dv_den[0] = r_den4;
    assign w_dv_quo[0] = '0;

    for (genvar gq = 0; gq < RATIO_W; gq++) begin : g_div
        tar_div_cell #(.DEN_W(DEN_W)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_rem (w_dv_rem[gq]),
            .i_num (w_dv_num[gq]),
            .i_den (w_dv_den[gq]),
            .i_quo (w_dv_quo[gq]),
            .o_rem (w_dv_rem[gq+1]),
            .o_num (w_dv_num[gq+1]),
            .o_den (w_dv_den[gq+1]),
            .o_quo (w_dv_quo[gq+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dsat[0] <= r_sat4;
            r_ddeg[0] <= r_deg4;
            for (int k = 1; k < RATIO_W; k++) begin
                r_dsat[k] <= r_dsat[k-1];
                r_ddeg[k] <= r_ddeg[k-1];
            end
        end
    end

    // ------------------------------------------------ output register + skid
    t_ratio n_res_ratio;
    logic   n_res_deg;
    logic   w_push;
    logic   w_take;
    logic   r_out_vld;
    t_ratio r_out_ratio;
    logic   r_out_deg;
    t_ratio r_skid_ratio;
    logic   r_skid_deg;

    always_comb begin
        n_res_deg   = r_ddeg[RATIO_W-1];
        n_res_ratio = (r_ddeg[RATIO_W-1] || r_dsat[RATIO_W-1]) ? '1 : w_dv_quo[RATIO_W];
    end

    assign w_push = w_adv && r_vld[NSTG-1];
    assign w_take = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_vld && !w_take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out_ratio <= r_skid_ratio;
                r_out_deg   <= r_skid_deg;
            end
        end else if (w_push) begin
            if (r_out_vld && !w_take) begin
                r_skid_ratio <= n_res_ratio;
                r_skid_deg   <= n_res_deg;
            end else begin
                r_out_ratio <= n_res_ratio;
                r_out_deg   <= n_res_deg;
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_ratio      = r_out_ratio;
    assign o_degenerate = r_out_deg;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held with empty output register");

    a_deg_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_ratio == '1))
        else $error("degenerate word without saturated ratio");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> $stable(r_vld))
        else $error("pipeline moved while output buffer full");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without a held output word");
`endif

endmodule

// ===== sv/tar_sqrt_cell.sv =====
// One digit cell of the pipelined restoring square root.
module tar_sqrt_cell import tar_pkg::*; #(
    parameter int ROOT_W = 50
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [ROOT_W+1:0]   i_rem,
    input  logic [ROOT_W-1:0]   i_root,
    input  logic [2*ROOT_W-1:0] i_arg,
    output logic [ROOT_W+1:0]   o_rem,
    output logic [ROOT_W-1:0]   o_root,
    output logic [2*ROOT_W-1:0] o_arg
);

    localparam int ARG_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CUR_W = REM_W + SQRT_STEP;

    logic [CUR_W-1:0]  n_cur;
    logic [CUR_W-1:0]  n_trial;
    logic [CUR_W-1:0]  n_diff;
    logic              n_fit;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;
    logic [ARG_W-1:0]  n_arg;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ARG_W-1:0]  r_arg;

    always_comb begin
        n_cur   = {i_rem, i_arg[ARG_W-1 -: SQRT_STEP]};
        n_trial = CUR_W'({i_root, 2'b01});   // 4*root + 1
        n_diff  = n_cur - n_trial;
        n_fit   = (n_cur >= n_trial);
        n_rem   = n_fit ? n_diff[REM_W-1:0] : n_cur[REM_W-1:0];
        n_root  = {i_root[ROOT_W-2:0], n_fit};
        n_arg   = {i_arg[ARG_W-SQRT_STEP-1:0], {SQRT_STEP{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_arg  <= n_arg;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_arg  = r_arg;

endmodule

// ===== sv/tar_div_cell.sv =====
// One quotient-bit cell of the pipelined restoring divider.
module tar_div_cell import tar_pkg::*; #(
    parameter int DEN_W = 86
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,
    input  t_ratio           i_num,
    input  logic [DEN_W-1:0] i_den,
    input  t_ratio           i_quo,
    output logic [DEN_W-1:0] o_rem,
    output t_ratio           o_num,
    output logic [DEN_W-1:0] o_den,
    output t_ratio           o_quo
);

    logic [DEN_W:0]   n_cur;
    logic [DEN_W:0]   n_diff;
    logic             n_fit;
    logic [DEN_W-1:0] n_rem;
    logic [DEN_W-1:0] r_rem;
    t_ratio           r_num;
    logic [DEN_W-1:0] r_den;
    t_ratio           r_quo;

    always_comb begin
        n_cur  = {i_rem, i_num[RATIO_W-1]};
        n_diff = n_cur - {1'b0, i_den};
        n_fit  = (n_cur >= {1'b0, i_den});
        n_rem  = n_fit ? n_diff[DEN_W-1:0] : n_cur[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= {i_num[RATIO_W-2:0], 1'b0};
            r_den <= i_den;
            r_quo <= {i_quo[RATIO_W-2:0], n_fit};
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

// ===== dv/tetra_aspect_ratio_checker.sv =====
// Checker for the tetrahedron aspect ratio pipeline: predicts each word and compares.
module tetra_aspect_ratio_checker import tar_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  logic [191:0]   i_tet,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  t_ratio         i_ratio,
    input  logic           i_degenerate,
    output int             o_errors,
    output int             o_pending,
    output int             o_degen_seen,
    output int             o_sat_seen
);

    typedef struct packed {
        t_ratio ratio;
        logic   degenerate;
    } t_shape;

    localparam logic [127:0] RATIO_CEIL = 128'hFFFF_FFFF;

    t_shape shape_q[$];

    function automatic logic [127:0] root_floor(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    // floor(sqrt(|(q-p) x (r-p)|^2 * 2^32))
    function automatic logic [127:0] face_q16(input longint p[3], input longint q[3],
                                              input longint r[3]);
        longint u[3];
        longint v[3];
        longint w[3];
        logic [127:0] s;
        logic [127:0] m;
        for (int k = 0; k < 3; k++) begin
            u[k] = q[k] - p[k];
            v[k] = r[k] - p[k];
        end
        w[0] = u[1] * v[2] - u[2] * v[1];
        w[1] = u[2] * v[0] - u[0] * v[2];
        w[2] = u[0] * v[1] - u[1] * v[0];
        s = '0;
        for (int k = 0; k < 3; k++) begin
            m = 128'(w[k] < 0 ? -w[k] : w[k]);
            s = s + m * m;
        end
        return root_floor(s << 32);
    endfunction

    function automatic t_shape predict_shape(input logic [191:0] tet);
        longint pt[4][3];
        longint e1[3];
        longint e2[3];
        longint e3[3];
        longint cr[3];
        longint six_vol;
        longint d;
        logic [127:0] edge_sq;
        logic [127:0] max_sq;
        logic [127:0] len_q;
        logic [127:0] area_q;
        logic [127:0] quot;
        t_shape res;
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
                pt[i][k] = longint'($signed(tet[(i*3+k)*16 +: 16]));
        for (int k = 0; k < 3; k++) begin
            e1[k] = pt[1][k] - pt[0][k];
            e2[k] = pt[2][k] - pt[0][k];
            e3[k] = pt[3][k] - pt[0][k];
        end
        cr[0] = e2[1] * e3[2] - e2[2] * e3[1];
        cr[1] = e2[2] * e3[0] - e2[0] * e3[2];
        cr[2] = e2[0] * e3[1] - e2[1] * e3[0];
        six_vol = e1[0] * cr[0] + e1[1] * cr[1] + e1[2] * cr[2];
        if (six_vol < 0) six_vol = -six_vol;
        if (six_vol == 0) begin
            res.ratio = '1;
            res.degenerate = 1'b1;
            return res;
        end
        // longest of all edges
        max_sq = '0;
        for (int i = 0; i < 4; i++)
            for (int j = i + 1; j < 4; j++) begin
                edge_sq = '0;
                for (int k = 0; k < 3; k++) begin
                    d = pt[j][k] - pt[i][k];
                    edge_sq = edge_sq + 128'(d * d);
                end
                if (edge_sq > max_sq) max_sq = edge_sq;
            end
        len_q  = root_floor(max_sq << 32);
        area_q = face_q16(pt[0], pt[1], pt[2]) + face_q16(pt[0], pt[1], pt[3])
               + face_q16(pt[0], pt[2], pt[3]) + face_q16(pt[1], pt[2], pt[3]);
        quot = ((len_q * area_q) << 16) / (128'(six_vol) * 128'(TWO_SQRT6_Q32));
        res.ratio = (quot > RATIO_CEIL) ? '1 : t_ratio'(quot);
        res.degenerate = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_degen_seen = 0;
        o_sat_seen = 0;
    end

    always @(posedge i_clk) begin
        t_shape want;
        if (i_rst_n && i_in_valid && !i_in_stall)
            shape_q.push_back(predict_shape(i_tet));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (shape_q.size() == 0) begin
                report_mismatch("unexpected word ratio", i_ratio, 0);
            end else begin
                want = shape_q.pop_front();
                if (i_ratio !== want.ratio)
                    report_mismatch("ratio", i_ratio, want.ratio);
                if (i_degenerate !== want.degenerate)
                    report_mismatch("degenerate", i_degenerate, want.degenerate);
                if (want.degenerate) o_degen_seen++;
                else if (want.ratio == '1) o_sat_seen++;
            end
        end
        o_pending = shape_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the aspect ratio testbench: clock, reset, stimulus, backpressure, verdict.
module testbench import tar_pkg::*; ();

    localparam int NUM_RANDOM = 530;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    logic [191:0] tet_word;     // a_x at bits 15:0 ... d_z at bits 191:176
    logic         out_valid;
    logic         out_stall;
    t_ratio       ratio;
    logic         degenerate;

    int errors;
    int pending;
    int degen_seen;
    int sat_seen;
    int cycles;
    int words_sent;
    int tx_idle_max;            // sender gap ceiling, 0 for back-to-back stretches
    int rx_idle_max;            // receiver stall ceiling

    tetra_aspect_ratio i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_a_x        (tet_word[0*16 +: 16]),
        .i_a_y        (tet_word[1*16 +: 16]),
        .i_a_z        (tet_word[2*16 +: 16]),
        .i_b_x        (tet_word[3*16 +: 16]),
        .i_b_y        (tet_word[4*16 +: 16]),
        .i_b_z        (tet_word[5*16 +: 16]),
        .i_c_x        (tet_word[6*16 +: 16]),
        .i_c_y        (tet_word[7*16 +: 16]),
        .i_c_z        (tet_word[8*16 +: 16]),
        .i_d_x        (tet_word[9*16 +: 16]),
        .i_d_y        (tet_word[10*16 +: 16]),
        .i_d_z        (tet_word[11*16 +: 16]),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_ratio      (ratio),
        .o_degenerate (degenerate)
    );

    tetra_aspect_ratio_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_tet        (tet_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_ratio      (ratio),
        .i_degenerate (degenerate),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_degen_seen (degen_seen),
        .o_sat_seen   (sat_seen)
    );

    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Runaway guard.
    initial cycles = 0;
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words outstanding", cycles, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Packs four corners, coordinates in x, y, z order.
    function automatic logic [191:0] pack_tet(input int ax, input int ay, input int az,
                                              input int bx, input int by, input int bz,
                                              input int cx, input int cy, input int cz,
                                              input int dx, input int dy, input int dz);
        return {dz[15:0], dy[15:0], dx[15:0], cz[15:0], cy[15:0], cx[15:0],
                bz[15:0], by[15:0], bx[15:0], az[15:0], ay[15:0], ax[15:0]};
    endfunction

    function automatic int small_coord(input int span);
        return $urandom_range(2 * span, 0) - span;
    endfunction

    // Random tetrahedron: proper shapes, plus full-range noise,
    // flat/duplicate-corner shapes and slivers that push the ratio high.
    function automatic logic [191:0] rand_tet();
        logic [191:0] w;
        int c[12];
        int span;
        int pick;
        int src;
        int dst;
        pick = $urandom_range(9, 0);
        span = (1 << $urandom_range(15, 1)) - 1;
        for (int k = 0; k < 12; k++) c[k] = small_coord(span);
        case (pick)
            0, 1, 2: begin
                for (int k = 0; k < 12; k++) c[k] = $urandom();
            end
            6: begin            // two corners coincide
                src = $urandom_range(3, 0);
                dst = (src + 1 + $urandom_range(2, 0)) % 4;
                for (int k = 0; k < 3; k++) c[dst*3+k] = c[src*3+k];
            end
            7: begin            // all corners share one axis value
                src = $urandom_range(2, 0);
                for (int i = 1; i < 4; i++) c[i*3+src] = c[src];
            end
            8: begin            // sliver: fourth corner one step off the first corner
                for (int k = 0; k < 3; k++) c[9+k] = c[k];
                c[9 + $urandom_range(2, 0)] += ($urandom_range(1, 0) ? 1 : -1);
            end
            default: ;
        endcase
        for (int k = 0; k < 12; k++) w[k*16 +: 16] = c[k][15:0];
        return w;
    endfunction

    task automatic send_tet(input logic [191:0] w);
        int gap;
        gap = $urandom_range(tx_idle_max, 0);
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
        @(negedge clk);
        in_valid <= 1'b1;
        tet_word <= w;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // Receiver backpressure: a random stall before each result word.
    initial begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            n = $urandom_range(rx_idle_max, 0);
            repeat (n) @(negedge clk) out_stall <= 1'b1;
            @(negedge clk) out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        in_valid = 1'b0;
        tet_word = '0;
        words_sent = 0;
        tx_idle_max = 9;
        rx_idle_max = 9;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero volume, unit shapes, coordinate extremes, overflow.
        send_tet('0);                                           // all corners at origin
        send_tet(pack_tet(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256));
        send_tet(pack_tet(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, -256));
        send_tet(pack_tet(256, 256, 256, 256, -256, -256, -256, 256, -256,
                          -256, -256, 256));                    // regular
        send_tet(pack_tet(-32768, -32768, -32768, 32767, -32768, -32768,
                          -32768, 32767, -32768, -32768, -32768, 32767));
        send_tet(pack_tet(32767, 32767, 32767, -32768, 32767, 32767,
                          32767, -32768, 32767, 32767, 32767, -32768));
        send_tet(pack_tet(-32768, 0, 0, 32767, 0, 0, 0, -32768, 32767,
                          0, 32767, -32768));
        send_tet(pack_tet(-32768, -32768, -32768, 32767, 32767, 32767,
                          -32768, 32767, -32768, 32767, -32768, 32767));
        send_tet(pack_tet(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));   // smallest
        send_tet(pack_tet(0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 50, 0));   // coplanar
        send_tet(pack_tet(5, 5, 5, 5, 5, 5, 9, 1, 3, -4, 2, 7));        // repeated corner
        send_tet(pack_tet(0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 4, 5));         // collinear three
        // Nearly flat sliver: quotient overflows and saturates, not degenerate.
        send_tet(pack_tet(0, 0, 0, 32767, 32766, 0, 32766, 32765, 0, 0, 0, 1));
        send_tet(pack_tet(-32768, -32768, 0, 32767, 32766, 0, 32766, 32765, 0,
                          0, 0, -1));
        send_tet(pack_tet(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0));
        send_tet(pack_tet(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, -32768, -32768,
                          -32768));

        // Let everything drain once before the random traffic.
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            // Alternate between idle-heavy and back-to-back stretches.
            if (i % 100 == 0) begin
                tx_idle_max = (i % 200 == 0) ? 9 : 0;
                rx_idle_max = (i % 300 == 100) ? 0 : 9;
            end
            if (i == NUM_RANDOM / 2) begin
                @(negedge clk) in_valid <= 1'b0;
                while (pending != 0) @(posedge clk);
            end
            send_tet(rand_tet());
        end
        @(negedge clk) in_valid <= 1'b0;
        rx_idle_max = 9;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d tetrahedra in %0d cycles: %0d zero-volume, %0d saturated ratios",
                 words_sent, cycles, degen_seen, sat_seen);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d words missing", errors, pending);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== tetra_aspect_ratio.f =====
sv/tar_pkg.sv
sv/tar_sqrt_cell.sv
sv/tar_div_cell.sv
sv/tetra_aspect_ratio.sv
dv/tetra_aspect_ratio_checker.sv
dv/testbench.sv
